### hw/rtl/midi_song_event_parser_macros.svh
// assertion macros for the parser top level
`ifndef MIDI_SONG_EVENT_PARSER_MACROS_SVH
`define MIDI_SONG_EVENT_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MSEP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msep same-cycle check failed");

// antecedent implies consequent in the next cycle
`define MSEP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msep next-cycle check failed");

`endif

### hw/rtl/msep_pkg.sv
package msep_pkg;

	typedef enum logic [3:0] {
		PH_EVENT,
		PH_META_TYPE,
		PH_META_LEN,
		PH_META_DATA,
		PH_NOTE_KEY,
		PH_NOTE_VEL,
		PH_CTRL_NUM,
		PH_CTRL_VAL,
		PH_PROG,
		PH_DELTA
	} phase_t;

	typedef enum logic [3:0] {
		KIND_NOTE,
		KIND_TRACKVOL,
		KIND_EXPR,
		KIND_TREMLEVEL,
		KIND_TREMRATE,
		KIND_PROGRAM,
		KIND_DELTA,
		KIND_LOOPSTART,
		KIND_LOOPEND,
		KIND_END
	} kind_t;

	localparam logic [7:0] BYTE_META   = 8'hff;
	localparam logic [7:0] META_END    = 8'h2f;
	localparam logic [7:0] META_MARKER = 8'h06;
	localparam logic [7:0] MARK_START  = 8'h53;
	localparam logic [7:0] MARK_END    = 8'h45;
	localparam logic [3:0] STAT_NOTE   = 4'h9;
	localparam logic [3:0] STAT_CTRL   = 4'hb;
	localparam logic [3:0] STAT_PROG   = 4'hc;
	localparam logic [7:0] CTRL_TRACKVOL  = 8'd7;
	localparam logic [7:0] CTRL_EXPR      = 8'd11;
	localparam logic [7:0] CTRL_TREMLEVEL = 8'd92;
	localparam logic [7:0] CTRL_TREMRATE  = 8'd100;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  chan;
		logic [7:0]  key;
		logic [15:0] value;
		logic        is_note;
	} event_t;

	typedef struct packed {
		logic        ev_valid;
		event_t      ev;
		logic        patch_we;
		logic [3:0]  patch_chan;
		logic [7:0]  patch_data;
	} parse_out_t;

endpackage

### hw/rtl/msep_if.sv
interface msep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] song_byte;

	modport source (output valid, output song_byte, input ready);
	modport sink (input valid, input song_byte, output ready);
endinterface

interface msep_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_kind;
	logic [3:0]  channel_number;
	logic [7:0]  key_number;
	logic [15:0] event_value;
	logic [7:0]  patch_number;

	modport source (output valid, output event_kind, output channel_number,
		output key_number, output event_value, output patch_number, input ready);
	modport sink (input valid, input event_kind, input channel_number,
		input key_number, input event_value, input patch_number, output ready);
endinterface

### hw/rtl/msep_parser.sv
module msep_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          song_byte,
	output msep_pkg::parse_out_t po
);

	msep_pkg::phase_t phase_q, phase_d;
	logic [7:0]  status_q, status_d;
	logic [7:0]  first_q, first_d;
	logic [15:0] delta_q, delta_d;
	logic        stopped_q, stopped_d;
	logic [15:0] delta_nx;

	// shift in seven bits, wrapping to 16
	assign delta_nx = {delta_q[8:0], song_byte[6:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= msep_pkg::PH_EVENT;
			status_q  <= '0;
			first_q   <= '0;
			delta_q   <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			status_q  <= status_d;
			first_q   <= first_d;
			delta_q   <= delta_d;
			stopped_q <= stopped_d;
		end
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		status_d  = status_q;
		first_d   = first_q;
		delta_d   = delta_q;
		stopped_d = stopped_q;
		if (!stopped_q) begin
			unique case (phase_q)
				msep_pkg::PH_META_TYPE: begin
					if (song_byte == msep_pkg::META_END) begin
						stopped_d = 1'b1;
						phase_d   = msep_pkg::PH_EVENT;
					end else if (song_byte == msep_pkg::META_MARKER) begin
						phase_d = msep_pkg::PH_META_LEN;
					end else begin
						phase_d = msep_pkg::PH_DELTA;
						delta_d = '0;
					end
				end
				msep_pkg::PH_META_LEN: phase_d = msep_pkg::PH_META_DATA;
				msep_pkg::PH_NOTE_KEY: begin
					first_d = song_byte;
					phase_d = msep_pkg::PH_NOTE_VEL;
				end
				msep_pkg::PH_CTRL_NUM: begin
					first_d = song_byte;
					phase_d = msep_pkg::PH_CTRL_VAL;
				end
				msep_pkg::PH_META_DATA, msep_pkg::PH_NOTE_VEL,
				msep_pkg::PH_CTRL_VAL, msep_pkg::PH_PROG: begin
					phase_d = msep_pkg::PH_DELTA;
					delta_d = '0;
				end
				msep_pkg::PH_DELTA: begin
					delta_d = delta_nx;
					if (!song_byte[7]) begin
						phase_d = msep_pkg::PH_EVENT;
					end
				end
				default: begin
					if (song_byte == msep_pkg::BYTE_META) begin
						phase_d = msep_pkg::PH_META_TYPE;
					end else if (song_byte[7]) begin
						status_d = song_byte;
						case (song_byte[7:4])
							msep_pkg::STAT_NOTE: phase_d = msep_pkg::PH_NOTE_KEY;
							msep_pkg::STAT_CTRL: phase_d = msep_pkg::PH_CTRL_NUM;
							msep_pkg::STAT_PROG: phase_d = msep_pkg::PH_PROG;
							default: begin
								phase_d = msep_pkg::PH_DELTA;
								delta_d = '0;
							end
						endcase
					end else begin
						// running status: this byte is the first data byte
						first_d = song_byte;
						case (status_q[7:4])
							msep_pkg::STAT_NOTE: phase_d = msep_pkg::PH_NOTE_VEL;
							msep_pkg::STAT_CTRL: phase_d = msep_pkg::PH_CTRL_VAL;
							default: begin
								phase_d = msep_pkg::PH_DELTA;
								delta_d = '0;
							end
						endcase
					end
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		po            = '0;
		po.ev.chan    = status_q[3:0];
		po.patch_chan = status_q[3:0];
		po.patch_data = song_byte;
		if (!stopped_q) begin
			unique case (phase_q)
				msep_pkg::PH_META_TYPE: begin
					if (song_byte == msep_pkg::META_END) begin
						po.ev_valid = 1'b1;
						po.ev.kind  = msep_pkg::KIND_END;
						po.ev.chan  = '0;
					end
				end
				msep_pkg::PH_META_DATA: begin
					po.ev.chan = '0;
					if (song_byte == msep_pkg::MARK_START) begin
						po.ev_valid = 1'b1;
						po.ev.kind  = msep_pkg::KIND_LOOPSTART;
					end else if (song_byte == msep_pkg::MARK_END) begin
						po.ev_valid = 1'b1;
						po.ev.kind  = msep_pkg::KIND_LOOPEND;
					end
				end
				msep_pkg::PH_NOTE_VEL: begin
					po.ev_valid   = 1'b1;
					po.ev.kind    = msep_pkg::KIND_NOTE;
					po.ev.key     = first_q;
					po.ev.value   = {8'h00, song_byte[6:0], 1'b0};
					po.ev.is_note = 1'b1;
				end
				msep_pkg::PH_CTRL_VAL: begin
					po.ev.value = {8'h00, song_byte[6:0], 1'b0};
					case (first_q)
						msep_pkg::CTRL_TRACKVOL: begin
							po.ev_valid = 1'b1;
							po.ev.kind  = msep_pkg::KIND_TRACKVOL;
						end
						msep_pkg::CTRL_EXPR: begin
							po.ev_valid = 1'b1;
							po.ev.kind  = msep_pkg::KIND_EXPR;
						end
						msep_pkg::CTRL_TREMLEVEL: begin
							po.ev_valid = 1'b1;
							po.ev.kind  = msep_pkg::KIND_TREMLEVEL;
						end
						msep_pkg::CTRL_TREMRATE: begin
							po.ev_valid = 1'b1;
							po.ev.kind  = msep_pkg::KIND_TREMRATE;
						end
						default: po.ev_valid = 1'b0;
					endcase
				end
				msep_pkg::PH_PROG: begin
					po.ev_valid = 1'b1;
					po.ev.kind  = msep_pkg::KIND_PROGRAM;
					po.ev.value = {8'h00, song_byte};
					po.patch_we = 1'b1;
				end
				msep_pkg::PH_DELTA: begin
					po.ev.chan = '0;
					if (!song_byte[7]) begin
						po.ev_valid = 1'b1;
						po.ev.kind  = msep_pkg::KIND_DELTA;
						po.ev.value = delta_nx;
					end
				end
				msep_pkg::PH_META_LEN, msep_pkg::PH_NOTE_KEY, msep_pkg::PH_CTRL_NUM: begin
					po.ev_valid = 1'b0;
				end
				default: begin
					// data byte under a program-change running status
					if (!song_byte[7] && status_q[7:4] == msep_pkg::STAT_PROG) begin
						po.ev_valid = 1'b1;
						po.ev.kind  = msep_pkg::KIND_PROGRAM;
						po.ev.value = {8'h00, song_byte};
						po.patch_we = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

### hw/rtl/msep_patch_mem.sv
module msep_patch_mem #(
	parameter int unsigned PATCH_CHANNELS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       we,
	input  logic [3:0] wr_chan,
	input  logic [7:0] wr_data,
	input  logic       rd_en,
	input  logic [3:0] rd_chan,
	output logic [7:0] rd_patch
);

	localparam int unsigned AW = (PATCH_CHANNELS > 1) ? $clog2(PATCH_CHANNELS) : 1;
	localparam logic [4:0] DEPTH = 5'(PATCH_CHANNELS);

	logic [7:0]  mem [PATCH_CHANNELS];
	logic [PATCH_CHANNELS-1:0] vld_q;
	logic        wr_in, rd_in;
	logic [AW-1:0] wa, ra;
	logic [7:0]  rd_q;
	logic        rv_q;

	assign wr_in = {1'b0, wr_chan} < DEPTH;
	assign rd_in = {1'b0, rd_chan} < DEPTH;
	assign wa    = wr_in ? wr_chan[AW-1:0] : '0;
	assign ra    = rd_in ? rd_chan[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (we && wr_in) begin
			mem[wa] <= wr_data;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we && wr_in) begin
			vld_q[wa] <= 1'b1;
		end
	end

	// write-first for a same-cycle hit on the read entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (rd_en) begin
			rv_q <= rd_in && (vld_q[ra] || (we && wr_in && wa == ra));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= (we && wr_in && wa == ra) ? wr_data : mem[ra];
		end
	end

	assign rd_patch = rv_q ? rd_q : 8'h00;

endmodule

### hw/rtl/midi_song_event_parser.sv
// song byte parser: one byte per cycle, accepted whenever the output register can move
// a byte's result is registered in s1, with the patch memory read registered alongside it,
// then in the output register; both advance only while the output register can move
// throughput: one byte per cycle while the output register can move, at most one result per byte
// reset: parse state, running status, delta and stop flag cleared; patch table reads
// zero through per-entry valid bits, no clearing pass needed
`include "midi_song_event_parser_macros.svh"

module midi_song_event_parser #(
	parameter int unsigned PATCH_CHANNELS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	msep_byte_if.sink    song,
	msep_event_if.source events
);

	msep_pkg::parse_out_t po;
	msep_pkg::event_t     ev_s1;
	logic        valid_s1;
	logic        en, accept;
	logic [7:0]  mem_patch;

	logic        out_valid_q;
	logic [3:0]  out_kind_q;
	logic [3:0]  out_chan_q;
	logic [7:0]  out_key_q;
	logic [15:0] out_value_q;
	logic [7:0]  out_patch_q;

	assign en         = !out_valid_q || events.ready;
	assign song.ready = en;
	assign accept     = song.valid && en;

	msep_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.song_byte (song.song_byte),
		.po        (po)
	);

	// read is issued with the decode, data lines up with the s1 beat
	msep_patch_mem #(
		.PATCH_CHANNELS (PATCH_CHANNELS)
	) u_patch_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (accept && po.patch_we),
		.wr_chan  (po.patch_chan),
		.wr_data  (po.patch_data),
		.rd_en    (en),
		.rd_chan  (po.ev.chan),
		.rd_patch (mem_patch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && po.ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ev_s1 <= po.ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_kind_q  <= ev_s1.kind;
			out_chan_q  <= ev_s1.chan;
			out_key_q   <= ev_s1.key;
			out_value_q <= ev_s1.value;
			out_patch_q <= ev_s1.is_note ? mem_patch : 8'h00;
		end
	end

	assign events.valid          = out_valid_q;
	assign events.event_kind     = out_kind_q;
	assign events.channel_number = out_chan_q;
	assign events.key_number     = out_key_q;
	assign events.event_value    = out_value_q;
	assign events.patch_number   = out_patch_q;

	`MSEP_ASSERT_NEXT(a_s1_holds_on_stall, valid_s1 && !en, valid_s1 && $stable(ev_s1))
	`MSEP_ASSERT_NEXT(a_result_enters_s1, accept && po.ev_valid, valid_s1)
	`MSEP_ASSERT_SAME(a_patch_only_on_note, out_valid_q && out_kind_q != msep_pkg::KIND_NOTE, out_patch_q == 8'h00)

endmodule

### tb/sv/song_check_pkg.sv
package song_check_pkg;
	import msep_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  chan;
		logic [7:0]  key;
		logic [15:0] value;
		logic [7:0]  patch;
	} song_event_t;

	class song_event_scoreboard;
		int unsigned patch_channels;
		phase_t      phase;
		logic [7:0]  status;
		logic [7:0]  held_data;
		logic [15:0] delta_acc;
		bit          stopped;
		logic [7:0]  patch_table [16];
		song_event_t expected_events [$];
		int unsigned errors;
		int unsigned checked;
		int unsigned kind_seen [10];

		function new(int unsigned channels = 16);
			patch_channels = channels;
			phase = PH_EVENT;
			status = '0;
			held_data = '0;
			delta_acc = '0;
			stopped = 0;
			foreach (patch_table[i]) patch_table[i] = '0;
			errors = 0;
			checked = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function void program_change(logic [7:0] b, output song_event_t ev);
			if (status[3:0] < patch_channels) patch_table[status[3:0]] = b;
			delta_acc = '0;
			phase = PH_DELTA;
			ev = '0;
			ev.kind = KIND_PROGRAM;
			ev.chan = status[3:0];
			ev.value = {8'h00, b};
		endfunction

		// advances the parse state by one song byte, returns 1 when an event completes
		function bit parse_byte(logic [7:0] b, output song_event_t ev);
			logic [3:0] chan;
			bit hit;
			hit = 0;
			ev = '0;
			chan = status[3:0];
			if (stopped) return 0;
			case (phase)
				PH_META_TYPE: begin
					if (b == META_END) begin
						stopped = 1;
						phase = PH_EVENT;
						ev.kind = KIND_END;
						hit = 1;
					end else if (b == META_MARKER) begin
						phase = PH_META_LEN;
					end else begin
						delta_acc = '0;
						phase = PH_DELTA;
					end
				end
				PH_META_LEN: phase = PH_META_DATA;
				PH_META_DATA: begin
					delta_acc = '0;
					phase = PH_DELTA;
					if (b == MARK_START) begin
						ev.kind = KIND_LOOPSTART;
						hit = 1;
					end else if (b == MARK_END) begin
						ev.kind = KIND_LOOPEND;
						hit = 1;
					end
				end
				PH_NOTE_KEY: begin
					held_data = b;
					phase = PH_NOTE_VEL;
				end
				PH_NOTE_VEL: begin
					delta_acc = '0;
					phase = PH_DELTA;
					ev.kind = KIND_NOTE;
					ev.chan = chan;
					ev.key = held_data;
					ev.value = {8'h00, b[6:0], 1'b0};
					ev.patch = (chan < patch_channels) ? patch_table[chan] : 8'h00;
					hit = 1;
				end
				PH_CTRL_NUM: begin
					held_data = b;
					phase = PH_CTRL_VAL;
				end
				PH_CTRL_VAL: begin
					delta_acc = '0;
					phase = PH_DELTA;
					hit = 1;
					case (held_data)
						CTRL_TRACKVOL:  ev.kind = KIND_TRACKVOL;
						CTRL_EXPR:      ev.kind = KIND_EXPR;
						CTRL_TREMLEVEL: ev.kind = KIND_TREMLEVEL;
						CTRL_TREMRATE:  ev.kind = KIND_TREMRATE;
						default:        hit = 0;
					endcase
					if (hit) begin
						ev.chan = chan;
						ev.value = {8'h00, b[6:0], 1'b0};
					end else begin
						ev = '0;
					end
				end
				PH_PROG: begin
					program_change(b, ev);
					hit = 1;
				end
				PH_DELTA: begin
					// shifted-in 7 bits never carry, so a concatenation does the wrap
					delta_acc = {delta_acc[8:0], b[6:0]};
					if (!b[7]) begin
						phase = PH_EVENT;
						ev.kind = KIND_DELTA;
						ev.value = delta_acc;
						hit = 1;
					end
				end
				default: begin
					if (b == BYTE_META) begin
						phase = PH_META_TYPE;
					end else if (b[7]) begin
						status = b;
						case (b[7:4])
							STAT_NOTE: phase = PH_NOTE_KEY;
							STAT_CTRL: phase = PH_CTRL_NUM;
							STAT_PROG: phase = PH_PROG;
							default: begin
								delta_acc = '0;
								phase = PH_DELTA;
							end
						endcase
					end else begin
						// running status
						held_data = b;
						case (status[7:4])
							STAT_NOTE: phase = PH_NOTE_VEL;
							STAT_CTRL: phase = PH_CTRL_VAL;
							STAT_PROG: begin
								program_change(b, ev);
								hit = 1;
							end
							default: begin
								delta_acc = '0;
								phase = PH_DELTA;
							end
						endcase
					end
				end
			endcase
			return hit;
		endfunction

		function void note_byte(logic [7:0] b);
			song_event_t ev;
			if (parse_byte(b, ev)) expected_events.push_back(ev);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("tb: mismatch: %s", msg);
		endtask

		task check_event(song_event_t got);
			song_event_t want;
			if (expected_events.size() == 0) begin
				report($sformatf("event kind %0d arrived with nothing pending", got.kind));
				return;
			end
			want = expected_events.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("event %0d kind %0d, want %0d", checked, got.kind, want.kind));
			if (got.chan !== want.chan)
				report($sformatf("event %0d channel %0d, want %0d", checked, got.chan, want.chan));
			if (got.key !== want.key)
				report($sformatf("event %0d key %0h, want %0h", checked, got.key, want.key));
			if (got.value !== want.value)
				report($sformatf("event %0d value %0h, want %0h", checked, got.value,
					want.value));
			if (got.patch !== want.patch)
				report($sformatf("event %0d patch %0h, want %0h", checked, got.patch,
					want.patch));
			kind_seen[want.kind]++;
			checked++;
		endtask
	endclass
endpackage

### tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import msep_pkg::*;
	import song_check_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_BYTES = 2000;
	localparam int unsigned QUIET_TAIL = 300;

	logic clk;
	logic arst_n;
	bit quiet;
	int unsigned cycles;
	int unsigned bytes_sent;
	int stall_left;

	msep_byte_if song ();
	msep_event_if events ();

	song_event_scoreboard sb = new(16);
	song_event_scoreboard stream_shadow = new(16);
	logic [7:0] song_stream [$];

	midi_song_event_parser #(.PATCH_CHANNELS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.song(song),
		.events(events)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		song.valid = 1'b0;
		song.song_byte = 8'h00;
		events.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// receiver side with random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			events.ready <= 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			events.ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			events.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		song_event_t got;
		if (arst_n && events.valid && events.ready) begin
			got.kind = kind_t'(events.event_kind);
			got.chan = events.channel_number;
			got.key = events.key_number;
			got.value = events.event_value;
			got.patch = events.patch_number;
			sb.check_event(got);
		end
	end

	// the shadow parser keeps random bytes from ending the song early
	task add_byte(logic [7:0] b, bit may_end = 0);
		song_event_t ev;
		if (!may_end && stream_shadow.phase == PH_META_TYPE && b == META_END) b = 8'h2e;
		void'(stream_shadow.parse_byte(b, ev));
		song_stream.push_back(b);
	endtask

	task add_delta();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 5);
		for (int i = 1; i < n; i++) add_byte(8'h80 | 8'($urandom_range(0, 127)));
		add_byte(8'($urandom_range(0, 127)));
	endtask

	task add_message();
		logic [7:0] s;
		bit running;
		running = ($urandom_range(0, 2) == 0);
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 7))
			0, 7: begin
				if (running) begin
					add_byte(8'($urandom_range(0, 127)));
				end else begin
					add_byte({STAT_NOTE, 4'($urandom_range(0, 15))});
					add_byte(8'($urandom_range(0, 255)));
				end
				add_byte(8'($urandom_range(0, 255)));
			end
			1: begin
				if (!running) add_byte({STAT_CTRL, 4'($urandom_range(0, 15))});
				case ($urandom_range(0, 4))
					0: s = CTRL_TRACKVOL;
					1: s = CTRL_EXPR;
					2: s = CTRL_TREMLEVEL;
					3: s = CTRL_TREMRATE;
					default: s = 8'($urandom_range(0, running ? 127 : 255));
				endcase
				add_byte(s);
				add_byte(8'($urandom_range(0, 255)));
			end
			2: begin
				if (running) begin
					add_byte(8'($urandom_range(0, 127)));
				end else begin
					add_byte({STAT_PROG, 4'($urandom_range(0, 15))});
					add_byte(8'($urandom_range(0, 255)));
				end
			end
			3: begin
				add_byte(BYTE_META);
				add_byte(META_MARKER);
				add_byte(8'($urandom_range(0, 255)));
				case ($urandom_range(0, 2))
					0: add_byte(MARK_START);
					1: add_byte(MARK_END);
					default: add_byte(8'($urandom_range(0, 255)));
				endcase
			end
			4: begin
				add_byte(BYTE_META);
				add_byte(8'($urandom_range(0, 255)));
			end
			5: begin
				do s = 8'($urandom_range(8'h80, 8'hfe));
				while (s[7:4] == STAT_NOTE || s[7:4] == STAT_CTRL || s[7:4] == STAT_PROG);
				add_byte(s);
			end
			default: add_byte(8'($urandom_range(0, 127)));
		endcase
		add_delta();
	endtask

	task build_song();
		logic [7:0] directed [$];
		directed = '{
			8'h12, 8'h00,
			{STAT_PROG, 4'h5}, 8'hff, 8'h00,
			{STAT_NOTE, 4'h5}, 8'h7f, 8'h7f, 8'hff, 8'hff, 8'h7f,
			{STAT_CTRL, 4'h3}, CTRL_TRACKVOL, 8'h40, 8'h00,
			CTRL_TREMRATE, 8'h02, 8'h00,
			BYTE_META, META_MARKER, 8'h01, MARK_START, 8'h00,
			{4'ha, 4'h3}, 8'h00,
			BYTE_META, 8'h01, 8'h00
		};
		foreach (directed[i]) add_byte(directed[i]);
		while (song_stream.size() < RANDOM_BYTES + directed.size()) add_message();
		while (stream_shadow.phase != PH_EVENT) add_byte(8'h00);
		add_byte(BYTE_META);
		add_byte(META_END, 1);
		// after the end every byte is dropped
		repeat (12) add_byte(8'($urandom_range(0, 255)));
	endtask

	task send_byte(logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			song.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		song.valid <= 1'b1;
		song.song_byte <= b;
		@(posedge clk);
		while (!song.ready) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	initial begin
		build_song();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (song_stream[i]) begin
			quiet = (i + QUIET_TAIL >= song_stream.size());
			send_byte(song_stream[i]);
		end
		song.valid <= 1'b0;
		while (sb.expected_events.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("tb: %0d song bytes in, %0d events checked", bytes_sent, sb.checked);
		$display("tb: notes %0d, program %0d, delta %0d, loop marks %0d, end %0d",
			sb.kind_seen[KIND_NOTE], sb.kind_seen[KIND_PROGRAM], sb.kind_seen[KIND_DELTA],
			sb.kind_seen[KIND_LOOPSTART] + sb.kind_seen[KIND_LOOPEND], sb.kind_seen[KIND_END]);
		if (sb.errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule
